// ===== src/drbt_pkg.sv =====
// Shared types and constants for the DRAM row buffer timing unit.
package drbt_pkg;

  localparam int CNT_W = 40;

  typedef logic [CNT_W-1:0] count_t;
  typedef logic [7:0]       lat_t;
  typedef logic [1:0]       outcome_t;
  typedef logic [1:0]       cfg_index_t;
  typedef logic [3:0]       cfg_data_t;

  localparam count_t CNT_MAX = {CNT_W{1'b1}};

  // latencies in cycles: bus 10, ACT/CAS/PRE 45 each
  localparam lat_t LAT_FIXED    = 8'd100;
  localparam lat_t LAT_HIT      = 8'd55;
  localparam lat_t LAT_EMPTY    = 8'd100;
  localparam lat_t LAT_CONFLICT = 8'd145;

  localparam outcome_t OUTCOME_FIXED    = 2'd0;
  localparam outcome_t OUTCOME_HIT      = 2'd1;
  localparam outcome_t OUTCOME_EMPTY    = 2'd2;
  localparam outcome_t OUTCOME_CONFLICT = 2'd3;

  localparam cfg_index_t CFG_FIXED_MODE  = 2'd0;
  localparam cfg_index_t CFG_OPEN_PAGE   = 2'd1;
  localparam cfg_index_t CFG_COLUMN_BITS = 2'd2;

  localparam logic [3:0] MAX_COLUMN_BITS = 4'd10;

  typedef struct packed {
    logic     valid;
    logic     is_write;
    lat_t     latency;
    outcome_t outcome;
  } result_t;

  typedef struct packed {
    lat_t     latency;
    outcome_t outcome;
    count_t   read_count;
    count_t   read_latency_sum;
    count_t   write_count;
    count_t   write_latency_sum;
  } entry_t;

endpackage

// ===== src/drbt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module drbt_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/drbt_bank_tracker.sv =====
// Open-row tracking: address split, row table lookup, hit/empty/conflict decision.
module drbt_bank_tracker #(
  parameter int BANK_COUNT   = 16,
  parameter int ADDRESS_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_fire,
  input  logic [31:0]       line_address,
  input  logic              is_write,
  input  logic              track_mode,
  input  logic [3:0]        col_width,
  output drbt_pkg::result_t res
);
  import drbt_pkg::*;

  localparam int BB = $clog2(BANK_COUNT + 1) - 1;   // floor(log2)
  localparam int IW = $clog2(BANK_COUNT);
  localparam int RW = ADDRESS_BITS - BB;

  logic [3:0]                cb;
  logic [ADDRESS_BITS+31:0]  addr_wide;
  logic [ADDRESS_BITS-1:0]   addr_a;
  logic [ADDRESS_BITS-1:0]   bank_sh;
  logic [ADDRESS_BITS-1:0]   row_sh;
  logic [4:0]                row_shamt;
  logic [IW-1:0]             bank_idx;
  logic [RW-1:0]             row_val;

  logic                      s1_valid;
  logic [IW-1:0]             s1_bank;
  logic [RW-1:0]             s1_row;
  logic                      s1_write;
  logic                      s1_track;

  logic [BANK_COUNT-1:0]     open_bits;
  logic                      fw_valid;
  logic [IW-1:0]             fw_bank;
  logic [RW-1:0]             fw_row;

  logic [RW-1:0]             ram_rdata;
  logic [RW-1:0]             stored_row;
  logic                      wr_en;
  lat_t                      lat;
  outcome_t                  outc;

  // request stage: split the address and start the row table read
  always_comb begin
    cb        = (col_width > MAX_COLUMN_BITS) ? MAX_COLUMN_BITS : col_width;
    addr_wide = {{ADDRESS_BITS{1'b0}}, line_address};
    addr_a    = addr_wide[ADDRESS_BITS-1:0];
    bank_sh   = addr_a >> cb;
    bank_idx  = IW'(bank_sh[BB-1:0]);
    row_shamt = 5'(BB) + 5'(cb);
    row_sh    = addr_a >> row_shamt;
    row_val   = row_sh[RW-1:0];
  end

  drbt_ram #(
    .WIDTH(RW),
    .DEPTH(BANK_COUNT)
  ) u_row_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(s1_bank),
    .wdata(s1_row),
    .raddr(bank_idx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= req_fire;
    end
    if (req_fire) begin
      s1_bank  <= bank_idx;
      s1_row   <= row_val;
      s1_write <= is_write;
      s1_track <= track_mode;
    end
  end

  // decision stage; a write from the previous request is not yet visible in the read data
  always_comb begin
    stored_row = (fw_valid && (fw_bank == s1_bank)) ? fw_row : ram_rdata;
    wr_en      = 1'b0;
    lat        = LAT_FIXED;
    outc       = OUTCOME_FIXED;
    if (s1_track) begin
      if (!open_bits[s1_bank]) begin
        lat   = LAT_EMPTY;
        outc  = OUTCOME_EMPTY;
        wr_en = s1_valid;
      end else if (stored_row == s1_row) begin
        lat  = LAT_HIT;
        outc = OUTCOME_HIT;
      end else begin
        lat   = LAT_CONFLICT;
        outc  = OUTCOME_CONFLICT;
        wr_en = s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_bits <= '0;
      fw_valid  <= 1'b0;
    end else begin
      fw_valid <= wr_en;
      if (wr_en) begin
        open_bits[s1_bank] <= 1'b1;
      end
    end
    fw_bank <= s1_bank;
    fw_row  <= s1_row;
  end

  assign res.valid    = s1_valid;
  assign res.is_write = s1_write;
  assign res.latency  = lat;
  assign res.outcome  = outc;

  a_opened_after_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> open_bits[$past(s1_bank)])
    else $error("bank not marked open after row write");

  a_forward_follows_write: assert property (@(posedge clk) disable iff (rst)
    fw_valid |-> $past(s1_valid))
    else $error("forwarded row without a preceding request");

endmodule

// ===== src/drbt_stats.sv =====
// Saturating read/write access counters and latency sums.
module drbt_stats (
  input  logic              clk,
  input  logic              rst,
  input  drbt_pkg::result_t res,
  output drbt_pkg::entry_t  entry
);
  import drbt_pkg::*;

  count_t          read_count;
  count_t          read_sum;
  count_t          write_count;
  count_t          write_sum;
  count_t          read_count_next;
  count_t          read_sum_next;
  count_t          write_count_next;
  count_t          write_sum_next;
  logic [CNT_W:0]  add_sum;

  always_comb begin
    read_count_next  = read_count;
    read_sum_next    = read_sum;
    write_count_next = write_count;
    write_sum_next   = write_sum;
    add_sum = {1'b0, (res.is_write ? write_sum : read_sum)} + (CNT_W+1)'(res.latency);
    if (res.valid) begin
      if (res.is_write) begin
        write_count_next = (write_count == CNT_MAX) ? CNT_MAX : write_count + count_t'(1);
        write_sum_next   = add_sum[CNT_W] ? CNT_MAX : add_sum[CNT_W-1:0];
      end else begin
        read_count_next = (read_count == CNT_MAX) ? CNT_MAX : read_count + count_t'(1);
        read_sum_next   = add_sum[CNT_W] ? CNT_MAX : add_sum[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_count  <= '0;
      read_sum    <= '0;
      write_count <= '0;
      write_sum   <= '0;
    end else begin
      read_count  <= read_count_next;
      read_sum    <= read_sum_next;
      write_count <= write_count_next;
      write_sum   <= write_sum_next;
    end
  end

  assign entry.latency           = res.latency;
  assign entry.outcome           = res.outcome;
  assign entry.read_count        = read_count_next;
  assign entry.read_latency_sum  = read_sum_next;
  assign entry.write_count       = write_count_next;
  assign entry.write_latency_sum = write_sum_next;

  a_read_leaves_writes: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.is_write) |=> (write_count == $past(write_count) &&
                                      write_sum == $past(write_sum)))
    else $error("read request changed write statistics");

endmodule

// ===== src/drbt_out_queue.sv =====
// Two-entry result queue between the decision stage and the output channel.
module drbt_out_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  drbt_pkg::entry_t push_entry,
  input  logic             out_stall,
  output logic             out_valid,
  output drbt_pkg::entry_t out_entry,
  output logic [1:0]       count
);
  import drbt_pkg::*;

  entry_t slots [2];
  logic   wr_ptr;
  logic   rd_ptr;
  logic   pop;

  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== src/dram_row_buffer_timing_unit.sv =====
// Top level of the DRAM row buffer timing unit.
//
// Takes one cache-line request per input handshake (line_address, is_write)
// and returns one result: latency in cycles, outcome code, and the running
// saturating read/write counts and latency sums including this request.
// Input and output use valid/stall; a request is taken when in_valid is high
// and in_stall low, a result leaves when out_valid is high and out_stall low.
// Configuration writes use cfg_valid/cfg_ready (always ready) with cfg_index:
// 0 fixed latency mode, 1 open page policy, 2 column field bits; other
// indexes are ignored. Write configuration only while the unit is idle.
// An accepted request is registered into the decision stage, and its result
// is then written into the result queue, whose output raises out_valid.
// Throughput: one request per cycle while in_stall is low; the row table
// RAM is read in the request cycle and written back in the next, with a
// one-entry forward path for back-to-back requests to the same bank.
// A two-entry result queue keeps the input open while a result waits; when
// the queue and the decision stage together hold two results and the
// receiver stalls, in_stall rises. Reset clears the open-row flags, the
// counters and the queue, and restores fixed mode, open page and four column bits.
module dram_row_buffer_timing_unit #(
  parameter int BANK_COUNT   = 16,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [31:0]            line_address,
  input  logic                   is_write,
  output logic                   out_valid,
  input  logic                   out_stall,
  output drbt_pkg::lat_t         latency,
  output drbt_pkg::outcome_t     outcome,
  output drbt_pkg::count_t       read_count,
  output drbt_pkg::count_t       read_latency_sum,
  output drbt_pkg::count_t       write_count,
  output drbt_pkg::count_t       write_latency_sum,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  drbt_pkg::cfg_index_t   cfg_index,
  input  drbt_pkg::cfg_data_t    cfg_data
);
  import drbt_pkg::*;

  logic       fixed_mode;
  logic       page_policy;
  logic [3:0] col_width;
  logic       req_fire;
  logic       pop;
  logic [1:0] q_count;
  logic [1:0] occupancy;
  result_t    trk_res;
  entry_t     stat_entry;
  entry_t     out_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_mode  <= 1'b1;
      page_policy <= 1'b1;
      col_width   <= 4'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIXED_MODE:  fixed_mode  <= cfg_data[0];
        CFG_OPEN_PAGE:   page_policy <= cfg_data[0];
        CFG_COLUMN_BITS: col_width   <= cfg_data;
        default: ;
      endcase
    end
  end

  // requests in flight: queued results plus the one in the decision stage
  assign occupancy = q_count + 2'(trk_res.valid);
  assign pop       = out_valid && !out_stall;
  assign in_stall  = (occupancy == 2'd2) && !pop;
  assign req_fire  = in_valid && !in_stall;

  drbt_bank_tracker #(
    .BANK_COUNT  (BANK_COUNT),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_tracker (
    .clk         (clk),
    .rst         (rst),
    .req_fire    (req_fire),
    .line_address(line_address),
    .is_write    (is_write),
    .track_mode  (!fixed_mode && page_policy),
    .col_width   (col_width),
    .res         (trk_res)
  );

  drbt_stats u_stats (
    .clk  (clk),
    .rst  (rst),
    .res  (trk_res),
    .entry(stat_entry)
  );

  drbt_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (trk_res.valid),
    .push_entry(stat_entry),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_entry (out_entry),
    .count     (q_count)
  );

  assign latency           = out_entry.latency;
  assign outcome           = out_entry.outcome;
  assign read_count        = out_entry.read_count;
  assign read_latency_sum  = out_entry.read_latency_sum;
  assign write_count       = out_entry.write_count;
  assign write_latency_sum = out_entry.write_latency_sum;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_count == 2'd2 && trk_res.valid))
    else $error("result queue overflow");

  a_request_decided: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> trk_res.valid)
    else $error("accepted request not in decision stage");

endmodule
